/* src/tbge_pkg.sv */
// Shared constants and types for the table bit group encoder.
`default_nettype none

package tbge_pkg;

    // Field widths fixed by the interface
    localparam int BYTE_BITS = 8;
    localparam int CNT_W     = 4;   // holds 0..BYTE_BITS
    localparam int ACC_W     = 6;   // group accumulator width
    localparam int IDX_W     = 6;   // symbol table index width
    localparam int SYM_W     = 8;   // table character width
    localparam int LEAD_W    = 3;
    localparam int SB_W      = 3;   // symbol_bits register width
    localparam int TBL_DEPTH = 64;

    // Default sizing
    localparam int DEF_MAX_SYMBOL_BITS = 6;
    localparam int DEF_IN_DEPTH        = 2;
    localparam int DEF_OUT_DEPTH       = 4;

    // Reset value of the symbol_bits register
    localparam logic [SB_W-1:0] SB_RESET = SB_W'(5);

    // Input action codes
    typedef enum logic {
        ACT_TABLE_WRITE = 1'b0,
        ACT_DATA_BYTE   = 1'b1
    } t_action;

    // Classified request from the front queue to the group engine
    typedef struct packed {
        t_action           action;
        logic [IDX_W-1:0]  index;
        logic [SYM_W-1:0]  tsym;
        logic [BYTE_BITS-1:0] data;
        logic              first;
        logic [LEAD_W-1:0] target;   // leading group size, 0 means full group
        logic              last;
    } t_cmd;

    // One result on its way to the output queue
    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             final_res;
    } t_res;

endpackage : tbge_pkg

`default_nettype wire

/* src/tbge_front.sv */
// Front end: input request queue that classifies each request on entry.
`default_nettype none

module tbge_front #(
    parameter int MAX_SYMBOL_BITS = tbge_pkg::DEF_MAX_SYMBOL_BITS,
    parameter int IN_DEPTH        = tbge_pkg::DEF_IN_DEPTH
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic [$clog2(MAX_SYMBOL_BITS+1)-1:0]  i_full_bits,
    input  wire logic                                  i_push,
    output logic                                       o_full,
    input  wire logic                                  i_action,
    input  wire logic [tbge_pkg::IDX_W-1:0]            i_table_index,
    input  wire logic [tbge_pkg::SYM_W-1:0]            i_table_symbol,
    input  wire logic [tbge_pkg::BYTE_BITS-1:0]        i_data_byte,
    input  wire logic                                  i_first,
    input  wire logic [tbge_pkg::LEAD_W-1:0]           i_lead_bits,
    input  wire logic                                  i_last,
    output logic                                       o_cmd_valid,
    output tbge_pkg::t_cmd                             o_cmd,
    input  wire logic                                  i_cmd_pop
);
    import tbge_pkg::*;

    localparam int PTR_W = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
    localparam int QCNT_W = $clog2(IN_DEPTH + 1);

    t_cmd              r_q [IN_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_push, do_pop;
    t_cmd              cls;

    // Classify: a lead group not below the group size counts as a full group
    always_comb begin
        cls.action = t_action'(i_action);
        cls.index  = i_table_index;
        cls.tsym   = i_table_symbol;
        cls.data   = i_data_byte;
        cls.first  = i_first;
        cls.last   = i_last;
        if (i_lead_bits != '0 && CNT_W'(i_lead_bits) < CNT_W'(i_full_bits)) begin
            cls.target = i_lead_bits;
        end else begin
            cls.target = '0;
        end
    end

    assign o_full      = (r_count == QCNT_W'(IN_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_cmd_pop && o_cmd_valid;

    // Pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(IN_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(IN_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

endmodule : tbge_front

`default_nettype wire

/* src/tbge_back.sv */
// Group engine: cuts message bytes into bit groups and looks them up in the symbol table.
`default_nettype none

module tbge_back #(
    parameter int MAX_SYMBOL_BITS = tbge_pkg::DEF_MAX_SYMBOL_BITS,
    parameter int OUT_DEPTH       = tbge_pkg::DEF_OUT_DEPTH
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic [$clog2(MAX_SYMBOL_BITS+1)-1:0]  i_full_bits,
    input  wire logic                                  i_cmd_valid,
    input  wire tbge_pkg::t_cmd                        i_cmd,
    output logic                                       o_cmd_pop,
    input  wire logic [$clog2(OUT_DEPTH+1)-1:0]        i_out_count,
    output logic                                       o_res_valid,
    output tbge_pkg::t_res                             o_res
);
    import tbge_pkg::*;

    localparam int FILL_W = $clog2(MAX_SYMBOL_BITS + 1);
    localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

    // Symbol table
    logic [SYM_W-1:0] r_table [TBL_DEPTH];
    logic [SYM_W-1:0] r_rd_data;

    // Engine state
    logic                 r_busy, n_busy;
    logic [BYTE_BITS-1:0] r_byte, n_byte;     // remaining bits, left aligned
    logic [CNT_W-1:0]     r_left, n_left;
    logic                 r_last, n_last;
    logic [ACC_W-1:0]     r_accum, n_accum;
    logic [FILL_W-1:0]    r_filled, n_filled;
    logic [LEAD_W-1:0]    r_target, n_target;
    logic                 r_b_valid;
    logic                 r_b_final;

    // Step datapath
    logic                 can_issue;
    logic                 take_new;
    logic                 is_write;
    logic                 step_en;
    logic [BYTE_BITS-1:0] src_byte;
    logic [CNT_W-1:0]     src_left;
    logic                 src_last;
    logic [ACC_W-1:0]     src_accum;
    logic [FILL_W-1:0]    src_filled;
    logic [LEAD_W-1:0]    src_target;
    logic [CNT_W-1:0]     tgt_eff;
    logic [CNT_W-1:0]     need;
    logic [CNT_W-1:0]     take;
    logic [BYTE_BITS-1:0] top_bits;
    logic [ACC_W+BYTE_BITS-1:0] acc_wide;
    logic [ACC_W-1:0]     grp;
    logic                 complete;
    logic                 exhausted;
    logic                 emit;
    logic                 emit_final;

    // Room downstream: queued results plus the one in the read stage
    assign can_issue = ({1'b0, i_out_count} + (OCNT_W+1)'(r_b_valid))
                       < (OCNT_W+1)'(OUT_DEPTH);

    assign is_write  = (i_cmd.action == ACT_TABLE_WRITE);
    assign take_new  = !r_busy && i_cmd_valid && (is_write || can_issue);
    assign o_cmd_pop = take_new;
    assign step_en   = (r_busy && can_issue) || (take_new && !is_write);

    // Source of this step: the byte in progress or a freshly taken one
    always_comb begin
        if (r_busy) begin
            src_byte   = r_byte;
            src_left   = r_left;
            src_last   = r_last;
            src_accum  = r_accum;
            src_filled = r_filled;
            src_target = r_target;
        end else begin
            src_byte   = i_cmd.data;
            src_left   = CNT_W'(BYTE_BITS);
            src_last   = i_cmd.last;
            if (i_cmd.first) begin
                src_accum  = '0;
                src_filled = '0;
                src_target = i_cmd.target;
            end else begin
                src_accum  = r_accum;
                src_filled = r_filled;
                src_target = r_target;
            end
        end
    end

    // One step fills the open group as far as the byte allows
    // (a group already at or past a narrowed width closes on the next bit)
    always_comb begin
        tgt_eff    = (src_target != '0) ? CNT_W'(src_target) : CNT_W'(i_full_bits);
        need       = (CNT_W'(src_filled) < tgt_eff) ? tgt_eff - CNT_W'(src_filled)
                                                    : CNT_W'(1);
        take       = (need < src_left) ? need : src_left;
        top_bits   = src_byte >> (CNT_W'(BYTE_BITS) - take);
        acc_wide   = ({{BYTE_BITS{1'b0}}, src_accum} << take)
                     | {{ACC_W{1'b0}}, top_bits};
        grp        = acc_wide[ACC_W-1:0];
        complete   = (take == need);
        exhausted  = (take == src_left);
        emit       = complete || (exhausted && src_last);
        emit_final = exhausted && src_last;
    end

    // Next engine state
    always_comb begin
        n_busy   = r_busy;
        n_byte   = r_byte;
        n_left   = r_left;
        n_last   = r_last;
        n_accum  = r_accum;
        n_filled = r_filled;
        n_target = r_target;
        if (step_en) begin
            n_byte = src_byte << take;
            n_left = src_left - take;
            n_last = src_last;
            n_busy = !exhausted;
            if (complete || emit_final) begin
                n_accum  = '0;
                n_filled = '0;
                n_target = '0;
            end else begin
                n_accum  = grp;
                n_filled = FILL_W'(CNT_W'(src_filled) + take);
                n_target = src_target;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_accum  <= '0;
            r_filled <= '0;
            r_target <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_accum  <= n_accum;
            r_filled <= n_filled;
            r_target <= n_target;
            r_b_valid <= step_en && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte    <= n_byte;
        r_left    <= n_left;
        r_last    <= n_last;
        r_b_final <= emit_final;
    end

    // Table write port and registered lookup
    always_ff @(posedge i_clk) begin
        if (take_new && is_write) begin
            r_table[i_cmd.index] <= i_cmd.tsym;
        end
        r_rd_data <= r_table[grp[IDX_W-1:0]];
    end

    assign o_res_valid      = r_b_valid;
    assign o_res.symbol     = r_rd_data;
    assign o_res.final_res  = r_b_final;

endmodule : tbge_back

`default_nettype wire

/* src/tbge_outq.sv */
// Output queue holding finished symbols until they are taken.
`default_nettype none

module tbge_outq #(
    parameter int OUT_DEPTH = tbge_pkg::DEF_OUT_DEPTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_res_valid,
    input  wire tbge_pkg::t_res                   i_res,
    output logic [$clog2(OUT_DEPTH+1)-1:0]        o_count,
    output logic                                  o_empty,
    input  wire logic                             i_pop,
    output tbge_pkg::t_res                        o_head
);
    import tbge_pkg::*;

    localparam int PTR_W  = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int QCNT_W = $clog2(OUT_DEPTH + 1);

    t_res              r_q [OUT_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_pop;

    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_head  = r_q[r_rd_ptr];
    assign do_pop  = i_pop && !o_empty;

    // Pointer and count update; the engine only pushes when there is room
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_res_valid) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_res_valid && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !i_res_valid) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_q[r_wr_ptr] <= i_res;
        end
    end

endmodule : tbge_outq

`default_nettype wire

/* src/table_bit_group_encoder.sv */
// Top level of the table bit group encoder.
`default_nettype none

// Turns a message, delivered one byte per request from the highest address down,
// into text symbols of symbol_bits bits each (clamped to 1..MAX_SYMBOL_BITS),
// looked up in a 64-entry table that action-0 requests load. A table write is
// taken by an idle group engine and yields no result. A message byte is handled
// one bit group at a time: it touches two or three groups for 5 or 6 bit symbols,
// eight for 1 bit symbols; the engine finishes at most one group per cycle and
// holds while the output queue lacks room. The input and output queues let the
// source and the sink stall on their own. The table has no reset; the
// configuration channel is always ready. The user must write it only while the
// block is idle; the block itself does not enforce this.
module table_bit_group_encoder #(
    parameter int MAX_SYMBOL_BITS = tbge_pkg::DEF_MAX_SYMBOL_BITS,
    parameter int IN_DEPTH        = tbge_pkg::DEF_IN_DEPTH,
    parameter int OUT_DEPTH       = tbge_pkg::DEF_OUT_DEPTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [tbge_pkg::SB_W-1:0]         i_cfg_data,
    // input queue side
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic                              i_action,
    input  wire logic [tbge_pkg::IDX_W-1:0]        i_table_index,
    input  wire logic [tbge_pkg::SYM_W-1:0]        i_table_symbol,
    input  wire logic [tbge_pkg::BYTE_BITS-1:0]    i_data_byte,
    input  wire logic                              i_first,
    input  wire logic [tbge_pkg::LEAD_W-1:0]       i_lead_bits,
    input  wire logic                              i_last,
    // result queue side
    output logic                                   empty,
    input  wire logic                              pop,
    output logic [tbge_pkg::SYM_W-1:0]             o_symbol,
    output logic                                   o_final_res
);
    import tbge_pkg::*;

    localparam int FILL_W = $clog2(MAX_SYMBOL_BITS + 1);
    localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

    logic [SB_W-1:0]   r_symbol_bits;
    logic [FILL_W-1:0] full_bits;
    logic              cmd_valid;
    t_cmd              cmd;
    logic              cmd_pop;
    logic [OCNT_W-1:0] out_count;
    logic              res_valid;
    t_res              res;
    t_res              head;

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_bits <= SB_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_symbol_bits <= i_cfg_data;
        end
    end

    // Effective group size, clamped to the supported range
    always_comb begin
        if (r_symbol_bits == '0) begin
            full_bits = FILL_W'(1);
        end else if (int'(r_symbol_bits) > MAX_SYMBOL_BITS) begin
            full_bits = FILL_W'(MAX_SYMBOL_BITS);
        end else begin
            full_bits = FILL_W'(r_symbol_bits);
        end
    end

    tbge_front #(
        .MAX_SYMBOL_BITS (MAX_SYMBOL_BITS),
        .IN_DEPTH        (IN_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_full_bits    (full_bits),
        .i_push         (push),
        .o_full         (full),
        .i_action       (i_action),
        .i_table_index  (i_table_index),
        .i_table_symbol (i_table_symbol),
        .i_data_byte    (i_data_byte),
        .i_first        (i_first),
        .i_lead_bits    (i_lead_bits),
        .i_last         (i_last),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .i_cmd_pop      (cmd_pop)
    );

    tbge_back #(
        .MAX_SYMBOL_BITS (MAX_SYMBOL_BITS),
        .OUT_DEPTH       (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_full_bits (full_bits),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_out_count (out_count),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    tbge_outq #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_count     (out_count),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_head      (head)
    );

    assign o_symbol    = head.symbol;
    assign o_final_res = head.final_res;

endmodule : table_bit_group_encoder

`default_nettype wire

/* src/tbge_chk.sv */
// Port-level checker for the table bit group encoder, with its bind.
`default_nettype none

module tbge_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       full,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] o_symbol,
    input wire logic       o_final_res
);

    // Reset drains the result queue
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // Reset frees the input queue
    a_rst_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input queue full after reset");

    // A result cannot reach the ports too early after reset
    a_rst_latency: assert property (@(posedge i_clk) !i_rst_n |=> empty ##1 empty)
        else $error("result appeared too early after reset");

    // A waiting result holds until it is popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_symbol) && $stable(o_final_res)))
        else $error("waiting result changed before pop");

endmodule : tbge_chk

bind table_bit_group_encoder tbge_chk u_tbge_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_symbol    (o_symbol),
    .o_final_res (o_final_res)
);

`default_nettype wire
